[hw/rtl/udf_pkg.sv]
// Shared types, constants and fold table for the UTF-8 diacritic folder.
package udf_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_CNT_W   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] LEAD_FIRST = 8'hC3;
    localparam logic [7:0] LEAD_LAST  = 8'hC9;
    localparam logic [7:0] DASH_B0    = 8'hE2;
    localparam logic [7:0] DASH_B1    = 8'h80;
    localparam logic [7:0] DASH_B2    = 8'h94;
    localparam logic [7:0] SHARP_S    = 8'h9F;
    localparam logic [7:0] EMPTY_MARK = 8'h2E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_S       = 8'h73;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Classified work item: up to three characters for the back end.
    typedef struct packed {
        logic [2:0]           nchar;
        logic [7:0]           c0;
        logic [7:0]           c1;
        logic [7:0]           c2;
        logic                 last;
        logic [OUT_CNT_W-1:0] count;
    } t_work;

    localparam string FOLD_ROM =
        {"AAAAAAACEEEEIIIIDNOOOOOxOUUUUYPsaaaaaaaceeeeiiiionooooo.ouuuuypy",
         "AaAaAACcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHHHHIIIIIIIIIIIIJJKKKLLLLLLL",
         "LLLNNNNNNNNNOOOOOOOORRRRRRSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzf",
         "bBbbbbCCCDDDDQEeeffGGhiIKKllmnnFSSSSPPRSsSrtTeTUuoNYyZzZzZzzsssR",
         "....JJJLLLNNNAAIiOOUuUuUuUuUueAaAaEeGgGgKkOoOOZzjZZzGgHPNnAaEaOo",
         "AaAaEeEeIiIiOoOoRrRrUuUuSsTtZzHhNdooZzAaEeOoOoOoOoYylntjffACcLTS",
         "ZCcBUAEeJjQqRrYyaaaaccppeeeeeewfggGGghhhiiIlcllmmmnnNocwFrrrrrtt"};

    function automatic logic [7:0] fold_lookup(input logic [2:0] lead, input logic [5:0] idx);
        return 8'(FOLD_ROM[{23'd0, lead} * 64 + {26'd0, idx}]);
    endfunction

endpackage

[hw/rtl/utf8_diacritic_fold_to_ascii.sv]
// Top level of the UTF-8 diacritic folder: front end, work queue, back end.
// One input byte is taken per cycle while the four-entry queue has room; each
// byte gives zero to three output characters, and the back end sends one per
// cycle while i_ready is high, so a byte that gives two or three characters
// (sharp s, a broken dash) holds the queue head until its last one is sent.
// Items pass the queue, then the output register; no reset sweep is needed.
module utf8_diacritic_fold_to_ascii import udf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_string_end,
    output logic [OUT_CNT_W-1:0] o_diacritic_count
);
    logic  f_wvalid, q_wready, q_rvalid, b_rready;
    t_work f_work, q_work;

    udf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_byte(i_in_byte), .i_last(i_in_last),
        .o_wvalid(f_wvalid), .i_wready(q_wready), .o_work(f_work)
    );

    udf_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wvalid(f_wvalid), .o_wready(q_wready), .i_work(f_work),
        .o_rvalid(q_rvalid), .i_rready(b_rready), .o_work(q_work)
    );

    udf_back u_back (
        .i_clk, .i_rst_n,
        .i_rvalid(q_rvalid), .o_rready(b_rready), .i_work(q_work),
        .o_valid, .i_ready, .o_char(o_out_char), .o_char_valid,
        .o_string_end, .o_diacritic_count
    );

    // A bare end marker carries no character
    a_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_string_end && o_out_char == 8'd0)
        else $error("bare marker malformed");
    // Count is shown only on the end of a string
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_string_end |-> o_diacritic_count == '0)
        else $error("count off string end");
    // Front end never offers an item while the queue is full
    a_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_wvalid |-> q_wready)
        else $error("queue overrun");
endmodule

[hw/rtl/udf_front.sv]
// Front end: decodes the byte stream and produces classified work items.
module udf_front import udf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic [7:0] i_byte,
    input  logic  i_last,
    output logic  o_wvalid,
    input  logic  i_wready,
    output t_work o_work
);
    typedef enum logic [1:0] {PK_NONE, PK_LEAD, PK_E2, PK_E280} t_pend;

    t_pend                  r_pend, n_pend;
    logic [2:0]             r_lead, n_lead;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    t_work                  w;
    logic                   is_lead, fresh, take;
    logic [7:0]             fold;
    logic [2:0]             fl;

    assign o_ready  = i_wready;
    assign take     = i_valid & i_wready;
    assign is_lead  = (i_byte >= LEAD_FIRST) && (i_byte <= LEAD_LAST);
    assign fl       = 3'(i_byte - LEAD_FIRST);
    assign fold     = fold_lookup(r_lead, i_byte[5:0]);

    // Decode one byte against the held state
    always_comb begin
        w = '0;
        n_pend = r_pend;
        n_lead = r_lead;
        n_cnt = r_cnt;
        fresh = 1'b0;
        case (r_pend)
            PK_LEAD: begin
                n_pend = PK_NONE;
                if (r_lead < 3'd7 && i_byte[7:6] == 2'b10) begin
                    if (fold != EMPTY_MARK) begin
                        w.c0 = fold;
                        w.nchar = 3'd1;
                    end
                    if (r_lead == 3'd0 && i_byte == SHARP_S) begin
                        w.c1 = CH_S;
                        w.nchar = 3'd2;
                    end
                end
            end
            PK_E2: begin
                if (i_byte == DASH_B1) begin
                    n_pend = PK_E280;
                end else begin
                    w.c0 = DASH_B0;
                    w.nchar = 3'd1;
                    fresh = 1'b1;
                end
            end
            PK_E280: begin
                n_pend = PK_NONE;
                if (i_byte == DASH_B2) begin
                    w.c0 = CH_DASH;
                    w.nchar = 3'd1;
                end else begin
                    w.c0 = DASH_B0;
                    w.c1 = DASH_B1;
                    w.nchar = 3'd2;
                    fresh = 1'b1;
                end
            end
            default: fresh = 1'b1;
        endcase
        // Fresh byte handling, appended after any flushed characters
        if (fresh) begin
            if (is_lead) begin
                if (r_cnt != COUNT_MAX) n_cnt = r_cnt + 1'b1;
                n_lead = fl;
                n_pend = PK_LEAD;
            end else if (i_byte == DASH_B0) begin
                n_pend = PK_E2;
            end else begin
                n_pend = PK_NONE;
                case (w.nchar)
                    3'd0:    w.c0 = i_byte;
                    3'd1:    w.c1 = i_byte;
                    default: w.c2 = i_byte;
                endcase
                w.nchar = w.nchar + 3'd1;
            end
        end
        // End of string flush of a held dash prefix
        if (i_last) begin
            if (n_pend == PK_E2) begin
                case (w.nchar)
                    3'd0:    w.c0 = DASH_B0;
                    3'd1:    w.c1 = DASH_B0;
                    default: w.c2 = DASH_B0;
                endcase
                w.nchar = w.nchar + 3'd1;
            end else if (n_pend == PK_E280) begin
                w.c0 = DASH_B0;
                w.c1 = DASH_B1;
                w.nchar = 3'd2;
            end
        end
        w.last  = i_last;
        w.count = OUT_CNT_W'(n_cnt);
    end

    assign o_wvalid = take & (i_last | (w.nchar != 3'd0));
    assign o_work   = w;

    // State update on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PK_NONE;
            r_lead <= '0;
            r_cnt  <= '0;
        end else if (take) begin
            if (i_last) begin
                r_pend <= PK_NONE;
                r_lead <= '0;
                r_cnt  <= '0;
            end else begin
                r_pend <= n_pend;
                r_lead <= n_lead;
                r_cnt  <= n_cnt;
            end
        end
    end
endmodule

[hw/rtl/udf_queue.sv]
// Short FIFO of work items between the front and back ends.
module udf_queue import udf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wvalid,
    output logic  o_wready,
    input  t_work i_work,
    output logic  o_rvalid,
    input  logic  i_rready,
    output t_work o_work
);
    t_work               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                wr, rd;

    assign o_wready = (r_cnt != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_rvalid = (r_cnt != '0);
    assign o_work   = r_mem[r_rp];
    assign wr = i_wvalid & o_wready;
    assign rd = o_rvalid & i_rready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_work;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(wr) - (QUEUE_AW+1)'(rd);
        end
    end
endmodule

[hw/rtl/udf_back.sv]
// Back end: expands work items into single-character output transfers.
module udf_back import udf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_rvalid,
    output logic  o_rready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output logic [7:0] o_char,
    output logic  o_char_valid,
    output logic  o_string_end,
    output logic [OUT_CNT_W-1:0] o_diacritic_count
);
    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_cv, r_end;
    logic [OUT_CNT_W-1:0] r_count;
    logic       load, final_one;
    logic [2:0] nout;
    logic [7:0] ch;

    assign nout      = (i_work.nchar == 3'd0) ? 3'd1 : i_work.nchar;
    assign final_one = ({1'b0, r_idx} + 3'd1 == nout);
    assign load      = i_rvalid & (~r_valid | i_ready);
    assign o_rready  = load & final_one;

    always_comb begin
        case (r_idx)
            2'd0:    ch = i_work.c0;
            2'd1:    ch = i_work.c1;
            default: ch = i_work.c2;
        endcase
    end

    // Output register and character index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx <= final_one ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cv    <= (i_work.nchar != 3'd0);
            r_char  <= (i_work.nchar != 3'd0) ? ch : 8'd0;
            r_end   <= final_one & i_work.last;
            r_count <= (final_one & i_work.last) ? i_work.count : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_char = r_char;
    assign o_char_valid = r_cv;
    assign o_string_end = r_end;
    assign o_diacritic_count = r_count;
endmodule
